// ----- rtl/session_admission_arbiter_assert.svh -----
// Assertion macros for the session admission arbiter checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SESSION_ADMISSION_ARBITER_ASSERT_SVH
`define SESSION_ADMISSION_ARBITER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define SAA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define SAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/saa_pkg.sv -----
// Shared types and constants for the session admission arbiter.
// No dependencies; imported by every module of the block.
package saa_pkg;

  // Field widths fixed by the interface
  localparam int unsigned FIELD_ID_BITS = 16;
  localparam int unsigned KEY_WORD_BITS = 64;
  localparam int unsigned KEY_BITS      = 4 * KEY_WORD_BITS;
  localparam int unsigned ID_BITS_DEF   = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;

  // Item modes as they arrive on the input
  localparam logic [1:0] MODE_ACT = 2'd0;
  localparam logic [1:0] MODE_ATT = 2'd1;
  localparam logic [1:0] MODE_END = 2'd2;

  // Ranks
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_PAIR = 2'd1;
  localparam logic [1:0] RANK_PLAY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_VALID = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_KEY0  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_KEY1  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_KEY2  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_KEY3  = 3'd4;

  // Operation after decode
  typedef enum logic [1:0] {
    OP_ACT,
    OP_ATT,
    OP_END,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [1:0]               mode;
    logic [FIELD_ID_BITS-1:0] conn_id;
    logic [KEY_WORD_BITS-1:0] server_key_0;
    logic [KEY_WORD_BITS-1:0] server_key_1;
    logic [KEY_WORD_BITS-1:0] server_key_2;
    logic [KEY_WORD_BITS-1:0] server_key_3;
    logic [1:0]               rank_in;
    logic                     first_activation;
    logic                     attempt_set;
  } in_item_t;

  typedef struct packed {
    logic                     admit;
    logic                     displaced_valid;
    logic [FIELD_ID_BITS-1:0] displaced_id;
    logic                     holder_valid;
    logic [FIELD_ID_BITS-1:0] holder_id;
    logic                     side_valid;
    logic [FIELD_ID_BITS-1:0] side_id;
    logic                     last_known;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    op_e                      op;
    logic [FIELD_ID_BITS-1:0] id;
    logic [KEY_BITS-1:0]      key;
    logic [1:0]               rank;
    logic                     first;
    logic                     prog;
  } cls_item_t;

endpackage

// ----- rtl/saa_front.sv -----
// Front end: accepts items, decodes mode, masks the id, saturates the rank,
// and holds up to two classified items for the back end. Uses saa_pkg.
module saa_front import saa_pkg::*; #(
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  input  logic      pop_i,
  output logic      head_valid_o,
  output cls_item_t head_o
);

  localparam int unsigned IdW = (ID_BITS < FIELD_ID_BITS) ? ID_BITS : FIELD_ID_BITS;

  cls_item_t  cls;
  cls_item_t  ent0_q, ent0_d, ent1_q, ent1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  // Classify the arriving item
  always_comb begin
    cls       = '0;
    cls.id    = '0;
    cls.id[IdW-1:0] = in_item_i.conn_id[IdW-1:0];
    cls.key   = {in_item_i.server_key_3, in_item_i.server_key_2,
                 in_item_i.server_key_1, in_item_i.server_key_0};
    cls.rank  = (in_item_i.rank_in > RANK_PLAY) ? RANK_PLAY : in_item_i.rank_in;
    cls.first = in_item_i.first_activation;
    cls.prog  = in_item_i.attempt_set;
    case (in_item_i.mode)
      MODE_ACT: cls.op = OP_ACT;
      MODE_ATT: cls.op = OP_ATT;
      MODE_END: cls.op = OP_END;
      default:  cls.op = OP_NONE;
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent0_q;

  // Two-entry shift queue, entry 0 is the head
  always_comb begin
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    cnt_d  = cnt_q;
    case ({push, pop_i})
      2'b01: begin
        ent0_d = ent1_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b10: begin
        if (cnt_q == 2'd0) ent0_d = cls;
        else               ent1_d = cls;
        cnt_d = cnt_q + 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          ent0_d = cls;
        end else begin
          ent0_d = ent1_q;
          ent1_d = cls;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

endmodule

// ----- rtl/saa_back.sv -----
// Back end: slot state, admission decision and the registered result.
// Also takes configuration writes of the last playback server. Uses saa_pkg.
module saa_back import saa_pkg::*; #(
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  cls_item_t                head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_item_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned IdW = (ID_BITS < FIELD_ID_BITS) ? ID_BITS : FIELD_ID_BITS;

  logic                hold_valid_q, hold_valid_d;
  logic [IdW-1:0]      hold_conn_q, hold_conn_d;
  logic [KEY_BITS-1:0] hold_server_q, hold_server_d;
  logic [1:0]          hold_rank_q, hold_rank_d;
  logic                hold_attempt_q, hold_attempt_d;
  logic                side_present_q, side_present_d;
  logic [IdW-1:0]      side_conn_q, side_conn_d;
  logic [KEY_BITS-1:0] side_server_q, side_server_d;
  logic [1:0]          side_rank_q, side_rank_d;
  logic                side_attempt_q, side_attempt_d;
  logic                last_present_q, last_present_d;
  logic [KEY_BITS-1:0] last_server_q, last_server_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, res;

  logic           fire, hit_hold, hit_side, arr_last, hold_last;
  logic           do_arb, put_h, put_att, admit, disp;
  logic [IdW-1:0] id_w, disp_id;

  assign fire        = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign id_w      = head_i.id[IdW-1:0];
  assign hit_hold  = hold_valid_q && (hold_conn_q == id_w);
  assign hit_side  = side_present_q && (side_conn_q == id_w);
  assign arr_last  = last_present_q && (last_server_q == head_i.key);
  assign hold_last = last_present_q && (last_server_q == hold_server_q);

  // Decision and next state
  always_comb begin
    hold_valid_d   = hold_valid_q;
    hold_conn_d    = hold_conn_q;
    hold_server_d  = hold_server_q;
    hold_rank_d    = hold_rank_q;
    hold_attempt_d = hold_attempt_q;
    side_present_d = side_present_q;
    side_conn_d    = side_conn_q;
    side_server_d  = side_server_q;
    side_rank_d    = side_rank_q;
    side_attempt_d = side_attempt_q;
    last_present_d = last_present_q;
    last_server_d  = last_server_q;
    do_arb  = 1'b0;
    put_h   = 1'b0;
    put_att = 1'b0;
    admit   = 1'b0;
    disp    = 1'b0;
    disp_id = '0;

    if (fire) begin
      case (head_i.op)
        OP_ACT: begin
          if (head_i.first && !hit_hold && !hit_side) begin
            do_arb = 1'b1;
          end else if (hit_hold) begin
            // re-activation of the holder keeps its attempt flag
            put_h   = 1'b1;
            put_att = hold_attempt_q;
            admit   = 1'b1;
          end else if (hit_side) begin
            if (head_i.rank == RANK_PAIR) begin
              admit = 1'b1;
            end else begin
              side_present_d = 1'b0;
              do_arb         = 1'b1;
            end
          end
        end
        OP_ATT: begin
          if (hit_hold)      hold_attempt_d = head_i.prog;
          else if (hit_side) side_attempt_d = head_i.prog;
        end
        OP_END: begin
          if (hit_hold) begin
            // side connection moves up into the hold slot
            hold_valid_d   = side_present_q;
            hold_conn_d    = side_conn_q;
            hold_server_d  = side_server_q;
            hold_rank_d    = side_rank_q;
            hold_attempt_d = side_attempt_q;
            side_present_d = 1'b0;
          end else if (hit_side) begin
            side_present_d = 1'b0;
          end
        end
        default: ;
      endcase

      // Arbitration of an incoming connection against the holder
      if (do_arb) begin
        if (!hold_valid_q) begin
          put_h = 1'b1;
          admit = 1'b1;
        end else if (hold_attempt_q) begin
          admit = 1'b0;
        end else if (head_i.rank == RANK_NONE && hold_rank_q == RANK_NONE) begin
          if (arr_last && !hold_last) begin
            put_h = 1'b1;
            admit = 1'b1;
            disp  = 1'b1;
          end
        end else if (hold_rank_q == RANK_PLAY && head_i.rank == RANK_PAIR) begin
          if (!side_present_q) begin
            side_present_d = 1'b1;
            side_conn_d    = id_w;
            side_server_d  = head_i.key;
            side_rank_d    = head_i.rank;
            side_attempt_d = 1'b0;
            admit          = 1'b1;
          end
        end else if (head_i.rank >= hold_rank_q) begin
          put_h = 1'b1;
          admit = 1'b1;
          disp  = 1'b1;
        end
      end

      if (disp) disp_id = hold_conn_q;

      // Load the hold slot; a playback holder becomes the last server
      if (put_h) begin
        hold_valid_d   = 1'b1;
        hold_conn_d    = id_w;
        hold_server_d  = head_i.key;
        hold_rank_d    = head_i.rank;
        hold_attempt_d = put_att;
        if (head_i.rank == RANK_PLAY) begin
          last_present_d = 1'b1;
          last_server_d  = head_i.key;
        end
      end
    end

    // Configuration preload of the last playback server
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LAST_VALID: last_present_d = cfg_data_i[0];
        CFG_LAST_KEY0:  last_server_d[0*KEY_WORD_BITS +: KEY_WORD_BITS] = cfg_data_i;
        CFG_LAST_KEY1:  last_server_d[1*KEY_WORD_BITS +: KEY_WORD_BITS] = cfg_data_i;
        CFG_LAST_KEY2:  last_server_d[2*KEY_WORD_BITS +: KEY_WORD_BITS] = cfg_data_i;
        CFG_LAST_KEY3:  last_server_d[3*KEY_WORD_BITS +: KEY_WORD_BITS] = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Result fields from the updated state
  always_comb begin
    res                 = '0;
    res.admit           = admit;
    res.displaced_valid = disp;
    res.displaced_id[IdW-1:0] = disp_id;
    res.holder_valid    = hold_valid_d;
    if (hold_valid_d) res.holder_id[IdW-1:0] = hold_conn_d;
    res.side_valid      = side_present_d;
    if (side_present_d) res.side_id[IdW-1:0] = side_conn_d;
    res.last_known      = last_present_d;
  end

  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q   <= 1'b0;
      hold_conn_q    <= '0;
      hold_server_q  <= '0;
      hold_rank_q    <= RANK_NONE;
      hold_attempt_q <= 1'b0;
      side_present_q <= 1'b0;
      side_conn_q    <= '0;
      side_server_q  <= '0;
      side_rank_q    <= RANK_NONE;
      side_attempt_q <= 1'b0;
      last_present_q <= 1'b0;
      last_server_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      hold_valid_q   <= hold_valid_d;
      hold_conn_q    <= hold_conn_d;
      hold_server_q  <= hold_server_d;
      hold_rank_q    <= hold_rank_d;
      hold_attempt_q <= hold_attempt_d;
      side_present_q <= side_present_d;
      side_conn_q    <= side_conn_d;
      side_server_q  <= side_server_d;
      side_rank_q    <= side_rank_d;
      side_attempt_q <= side_attempt_d;
      last_present_q <= last_present_d;
      last_server_q  <= last_server_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Result register, loaded whenever an item is carried out
  always_ff @(posedge clk_i) begin
    if (fire) out_item_q <= res;
  end

endmodule

// ----- rtl/session_admission_arbiter.sv -----
// Throughput: one item per cycle while the result is not stalled;
// each item yields exactly one result item. An accepted item is registered in the
// two-entry front queue, then decided and loaded into the result register.
// The input stalls only once both queue entries are full behind a stalled result.
// Reset (rst_ni low, asynchronous): both slots empty, no last playback server.
// Configuration writes are always ready and load the last playback server at once.
module session_admission_arbiter import saa_pkg::*; #(
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic      head_valid, pop;
  cls_item_t head;

  assign cfg_ready_o = 1'b1;

  // Front: accept and classify
  saa_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: decide, update slots, present result
  saa_back #(
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

endmodule

// ----- rtl/saa_checker.sv -----
// Port-level checks on the session admission arbiter, bound to the top level.
// Uses saa_pkg and the macros in session_admission_arbiter_assert.svh.
`include "session_admission_arbiter_assert.svh"

module saa_checker import saa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result stays put
  `SAA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "result changed while stalled")

  // A side connection only exists beside a holder
  `SAA_ASSERT_NOW(a_side_needs_hold, out_valid_o && out_item_o.side_valid, out_item_o.holder_valid, "side held without holder")

  // Displacement only comes with admission
  `SAA_ASSERT_NOW(a_disp_admit, out_valid_o && out_item_o.displaced_valid, out_item_o.admit, "displacement without admission")

  // Unused ids read as zero
  `SAA_ASSERT_NOW(a_disp_id_zero, out_valid_o && !out_item_o.displaced_valid, out_item_o.displaced_id == '0, "displaced id set without displacement")

  `SAA_ASSERT_NOW(a_hold_id_zero, out_valid_o && !out_item_o.holder_valid, out_item_o.holder_id == '0, "holder id set with no holder")

endmodule

bind session_admission_arbiter saa_checker u_saa_checker (.*);
